/* src/sjf_dispatcher_assert.svh */
// ---------------------------------------------------------------------------
// SJF dispatcher assertion macros
// Short forms for the port-level property checks of the dispatcher.
// ---------------------------------------------------------------------------
`ifndef SJF_DISPATCHER_ASSERT_SVH
`define SJF_DISPATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SJF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SJF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sjf_pkg.sv */
// ---------------------------------------------------------------------------
// SJF dispatcher package
// Request mode codes, result status codes and fixed field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package sjf_pkg;

	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int WAIT_W   = 32;
	localparam int TIME_W   = 32;

	// request modes
	localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADVANCE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_INSERTED   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DROPPED    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_ADVANCED   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FINISHED   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_DISPATCHED = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_NONE       = 3'd5;

	localparam logic [WAIT_W-1:0] WAIT_SAT = '1;
	localparam logic [TIME_W-1:0] TIME_SAT = '1;

endpackage

`default_nettype wire

/* src/sjf_alu.sv */
// ---------------------------------------------------------------------------
// SJF shared entry unit
// Saturating wait increment and burst compare, shared by the aging and scan sweeps.
// ---------------------------------------------------------------------------
`default_nettype none

module sjf_alu #(
	parameter int BURST_BITS = 16
) (
	input  wire logic [sjf_pkg::WAIT_W-1:0] wait_in,
	input  wire logic [BURST_BITS-1:0]      burst_a,
	input  wire logic [BURST_BITS-1:0]      burst_b,
	output logic      [sjf_pkg::WAIT_W-1:0] wait_inc,
	output logic                            less
);

	// aging: stop at all ones
	assign wait_inc = (wait_in == sjf_pkg::WAIT_SAT) ? wait_in
		: wait_in + sjf_pkg::WAIT_W'(1);

	// strict compare keeps the earliest entry on a tie
	assign less = (burst_a < burst_b);

endmodule

`default_nettype wire

/* src/sjf_table.sv */
// ---------------------------------------------------------------------------
// SJF ready table
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sjf_table #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 56
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/sjf_seq.sv */
// ---------------------------------------------------------------------------
// SJF sequencer
// Decodes requests and walks the ready table one entry a cycle for aging,
// minimum search and compaction, then holds the result in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sjf_seq #(
	parameter int READY_ENTRIES = 16,
	parameter int BURST_BITS    = 16,
	parameter int JOB_ID_BITS   = 8,
	parameter int IDX_W         = $clog2(READY_ENTRIES),
	parameter int ENT_W         = JOB_ID_BITS + BURST_BITS + sjf_pkg::WAIT_W
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request side
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [sjf_pkg::MODE_W-1:0]    in_mode,
	input  wire logic [JOB_ID_BITS-1:0]        in_id,
	input  wire logic [BURST_BITS-1:0]         in_burst,
	// result side
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [sjf_pkg::STATUS_W-1:0]  out_status,
	output logic      [JOB_ID_BITS-1:0]        out_job,
	output logic      [BURST_BITS-1:0]         out_burst,
	output logic      [sjf_pkg::WAIT_W-1:0]    out_wait,
	output logic      [sjf_pkg::TIME_W-1:0]    out_time,
	// table port
	output logic                               mem_we,
	output logic      [IDX_W-1:0]              mem_waddr,
	output logic      [ENT_W-1:0]              mem_wdata,
	output logic      [IDX_W-1:0]              mem_raddr,
	input  wire logic [ENT_W-1:0]              mem_rdata
);

	localparam int FILL_W = $clog2(READY_ENTRIES + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(READY_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AGE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [FILL_W-1:0]              fill_q;
	logic                           busy_q;
	logic [JOB_ID_BITS-1:0]         run_id_q;
	logic [BURST_BITS-1:0]          run_left_q;
	logic [sjf_pkg::TIME_W-1:0]     time_q;
	logic [FILL_W-1:0]              rd_idx_q;
	logic                           rv_s1;
	logic [IDX_W-1:0]               ridx_s1;
	logic [IDX_W-1:0]               best_idx_q;
	logic [JOB_ID_BITS-1:0]         best_id_q;
	logic [BURST_BITS-1:0]          best_burst_q;
	logic [sjf_pkg::WAIT_W-1:0]     best_wait_q;
	logic [sjf_pkg::STATUS_W-1:0]   res_status_q;
	logic [JOB_ID_BITS-1:0]         res_job_q;
	logic [BURST_BITS-1:0]          res_burst_q;
	logic [sjf_pkg::WAIT_W-1:0]     res_wait_q;
	logic                           out_valid_q;
	logic [sjf_pkg::STATUS_W-1:0]   out_status_q;
	logic [JOB_ID_BITS-1:0]         out_job_q;
	logic [BURST_BITS-1:0]          out_burst_q;
	logic [sjf_pkg::WAIT_W-1:0]     out_wait_q;
	logic [sjf_pkg::TIME_W-1:0]     out_time_q;

	logic                           accept;
	logic                           tbl_full;
	logic                           rd_issue;
	logic                           sweep_end;
	logic [JOB_ID_BITS-1:0]         rd_id;
	logic [BURST_BITS-1:0]          rd_burst;
	logic [sjf_pkg::WAIT_W-1:0]     rd_wait;
	logic [sjf_pkg::WAIT_W-1:0]     alu_wait_inc;
	logic                           alu_less;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign tbl_full = (fill_q == FILL_FULL);

	// read issue: one entry a cycle while a sweep is below the fill mark
	assign rd_issue  = ((state_q == ST_AGE) || (state_q == ST_SCAN) || (state_q == ST_SHIFT))
		&& (rd_idx_q < fill_q);
	assign sweep_end = !rd_issue && !rv_s1;
	assign mem_raddr = rd_idx_q[IDX_W-1:0];

	// entry fields: {wait, burst, id}
	assign rd_id    = mem_rdata[JOB_ID_BITS-1:0];
	assign rd_burst = mem_rdata[JOB_ID_BITS +: BURST_BITS];
	assign rd_wait  = mem_rdata[JOB_ID_BITS+BURST_BITS +: sjf_pkg::WAIT_W];

	sjf_alu #(
		.BURST_BITS(BURST_BITS)
	) u_alu (
		.wait_in (rd_wait),
		.burst_a (rd_burst),
		.burst_b (best_burst_q),
		.wait_inc(alu_wait_inc),
		.less    (alu_less)
	);

	// table write: insert, aged write-back, or move down by one
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q[IDX_W-1:0];
		mem_wdata = {sjf_pkg::WAIT_W'(0), in_burst, in_id};
		case (state_q)
			ST_IDLE: begin
				mem_we = accept && (in_mode == sjf_pkg::MODE_INSERT) && !tbl_full;
			end
			ST_AGE: begin
				mem_we    = rv_s1;
				mem_waddr = ridx_s1;
				mem_wdata = {alu_wait_inc, rd_burst, rd_id};
			end
			ST_SHIFT: begin
				mem_we    = rv_s1;
				mem_waddr = ridx_s1 - IDX_W'(1);
				mem_wdata = mem_rdata;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer, scheduler state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			busy_q       <= 1'b0;
			run_id_q     <= '0;
			run_left_q   <= '0;
			time_q       <= '0;
			rd_idx_q     <= '0;
			rv_s1        <= 1'b0;
			ridx_s1      <= '0;
			best_idx_q   <= '0;
			best_id_q    <= '0;
			best_burst_q <= '0;
			best_wait_q  <= '0;
			res_status_q <= '0;
			res_job_q    <= '0;
			res_burst_q  <= '0;
			res_wait_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_job_q    <= '0;
			out_burst_q  <= '0;
			out_wait_q   <= '0;
			out_time_q   <= '0;
		end else begin
			rv_s1   <= rd_issue;
			ridx_s1 <= rd_idx_q[IDX_W-1:0];
			if (rd_issue) begin
				rd_idx_q <= rd_idx_q + FILL_W'(1);
			end
			// a taken result drops valid unless the next one loads now
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_job_q   <= '0;
						res_burst_q <= '0;
						res_wait_q  <= '0;
						rd_idx_q    <= '0;
						case (in_mode)
							sjf_pkg::MODE_INSERT: begin
								state_q <= ST_DONE;
								if (tbl_full) begin
									res_status_q <= sjf_pkg::STAT_DROPPED;
								end else begin
									fill_q       <= fill_q + FILL_W'(1);
									res_status_q <= sjf_pkg::STAT_INSERTED;
								end
							end
							sjf_pkg::MODE_ADVANCE: begin
								if (time_q != sjf_pkg::TIME_SAT) begin
									time_q <= time_q + sjf_pkg::TIME_W'(1);
								end
								state_q <= ST_AGE;
							end
							sjf_pkg::MODE_DISPATCH: begin
								if (busy_q || (fill_q == '0)) begin
									res_status_q <= sjf_pkg::STAT_NONE;
									state_q      <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								// unused mode: dropped without a result
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_AGE: begin
					if (sweep_end) begin
						if (busy_q && (run_left_q != '0)) begin
							run_left_q <= run_left_q - BURST_BITS'(1);
						end
						// burst ends when one or zero units were left
						if (busy_q && (run_left_q <= BURST_BITS'(1))) begin
							busy_q       <= 1'b0;
							res_status_q <= sjf_pkg::STAT_FINISHED;
							res_job_q    <= run_id_q;
						end else begin
							res_status_q <= sjf_pkg::STAT_ADVANCED;
						end
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					// keep the first strictly shorter burst
					if (rv_s1 && ((ridx_s1 == '0) || alu_less)) begin
						best_idx_q   <= ridx_s1;
						best_id_q    <= rd_id;
						best_burst_q <= rd_burst;
						best_wait_q  <= rd_wait;
					end
					if (sweep_end) begin
						rd_idx_q <= FILL_W'(best_idx_q) + FILL_W'(1);
						state_q  <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (sweep_end) begin
						fill_q       <= fill_q - FILL_W'(1);
						busy_q       <= 1'b1;
						run_id_q     <= best_id_q;
						run_left_q   <= best_burst_q;
						res_status_q <= sjf_pkg::STAT_DISPATCHED;
						res_job_q    <= best_id_q;
						res_burst_q  <= best_burst_q;
						res_wait_q   <= best_wait_q;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_job_q    <= res_job_q;
						out_burst_q  <= res_burst_q;
						out_wait_q   <= res_wait_q;
						out_time_q   <= time_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_job    = out_job_q;
	assign out_burst  = out_burst_q;
	assign out_wait   = out_wait_q;
	assign out_time   = out_time_q;

endmodule

`default_nettype wire

/* src/sjf_dispatcher.sv */
// Insert and refused dispatch go straight to the result; advance ages every held entry in
// one table sweep; dispatch sweeps once for the shortest burst and once to move the later
// entries down. Each sweep reads one entry per cycle through the table port.
// Throughput: one request at a time; the next is taken once the result is in the
// output register, which may still be waiting on m_tready.
// Reset (arst_n low, asynchronous): table empty, CPU idle, time zero; no clearing pass.
// ---------------------------------------------------------------------------
// SJF dispatcher top level
// Non-preemptive shortest-job-first dispatcher with a ready table.
// ---------------------------------------------------------------------------
`default_nettype none

module sjf_dispatcher #(
	parameter int READY_ENTRIES = 16,
	parameter int BURST_BITS    = 16,
	parameter int JOB_ID_BITS   = 8,
	parameter int IN_W  = ((sjf_pkg::MODE_W + JOB_ID_BITS + BURST_BITS + 7) / 8) * 8,
	parameter int OUT_W = ((sjf_pkg::STATUS_W + JOB_ID_BITS + BURST_BITS
		+ sjf_pkg::WAIT_W + sjf_pkg::TIME_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// s_tdata: mode, job_id, burst_length, zero pad
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// m_tdata: status, out_job, out_burst, out_wait, out_time, zero pad
	output logic      [OUT_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(READY_ENTRIES);
	localparam int ENT_W = JOB_ID_BITS + BURST_BITS + sjf_pkg::WAIT_W;

	logic [sjf_pkg::MODE_W-1:0]   in_mode;
	logic [JOB_ID_BITS-1:0]       in_id;
	logic [BURST_BITS-1:0]        in_burst;
	logic [sjf_pkg::STATUS_W-1:0] out_status;
	logic [JOB_ID_BITS-1:0]       out_job;
	logic [BURST_BITS-1:0]        out_burst;
	logic [sjf_pkg::WAIT_W-1:0]   out_wait;
	logic [sjf_pkg::TIME_W-1:0]   out_time;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic [ENT_W-1:0]             mem_wdata;
	logic [IDX_W-1:0]             mem_raddr;
	logic [ENT_W-1:0]             mem_rdata;

	// request unpack
	assign in_mode  = s_tdata[sjf_pkg::MODE_W-1:0];
	assign in_id    = s_tdata[sjf_pkg::MODE_W +: JOB_ID_BITS];
	assign in_burst = s_tdata[sjf_pkg::MODE_W+JOB_ID_BITS +: BURST_BITS];

	// result pack, zero filled to whole bytes
	assign m_tdata = OUT_W'({out_time, out_wait, out_burst, out_job, out_status});

	sjf_table #(
		.DEPTH(READY_ENTRIES),
		.WIDTH(ENT_W)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sjf_seq #(
		.READY_ENTRIES(READY_ENTRIES),
		.BURST_BITS   (BURST_BITS),
		.JOB_ID_BITS  (JOB_ID_BITS),
		.IDX_W        (IDX_W),
		.ENT_W        (ENT_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (in_mode),
		.in_id     (in_id),
		.in_burst  (in_burst),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(out_status),
		.out_job   (out_job),
		.out_burst (out_burst),
		.out_wait  (out_wait),
		.out_time  (out_time),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

`default_nettype wire

/* src/sjf_chk.sv */
// ---------------------------------------------------------------------------
// SJF dispatcher port checker
// Port-level properties of the dispatcher, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sjf_dispatcher_assert.svh"

module sjf_chk #(
	parameter int JOB_ID_BITS = 8,
	parameter int IN_W        = 32,
	parameter int OUT_W       = 96
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic [IN_W-1:0]  s_tdata,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	logic [sjf_pkg::STATUS_W-1:0] status;
	logic [JOB_ID_BITS-1:0]       job;
	logic                         req_live;
	logic                         job_carrier;

	assign status      = m_tdata[sjf_pkg::STATUS_W-1:0];
	assign job         = m_tdata[sjf_pkg::STATUS_W +: JOB_ID_BITS];
	assign req_live    = s_tvalid && s_tready
		&& ((s_tdata[1:0] == sjf_pkg::MODE_INSERT) || (s_tdata[1:0] == sjf_pkg::MODE_ADVANCE)
		|| (s_tdata[1:0] == sjf_pkg::MODE_DISPATCH));
	assign job_carrier = (status == sjf_pkg::STAT_FINISHED)
		|| (status == sjf_pkg::STAT_DISPATCHED);

	// stalled result holds
	`SJF_ASSERT_NEXT(a_res_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// a live request leaves ready low in the cycle after it is taken
	`SJF_ASSERT_NEXT(a_busy_after_req, req_live, !s_tready, "ready stayed high after a request")

	// only defined status codes leave the block
	`SJF_ASSERT_NOW(a_status_range, m_tvalid, status <= sjf_pkg::STAT_NONE, "undefined status code")

	// job field is zero unless a job finished or was dispatched
	`SJF_ASSERT_NOW(a_job_zero, m_tvalid && !job_carrier, job == '0, "job set on a jobless result")

endmodule

bind sjf_dispatcher sjf_chk #(
	.JOB_ID_BITS(JOB_ID_BITS),
	.IN_W       (IN_W),
	.OUT_W      (OUT_W)
) u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

/* sim/sjf_dispatcher_tb.sv */
// ---------------------------------------------------------------------------
// SJF dispatcher testbench
// Sends insert, advance and dispatch requests over the input stream and
// checks every result against a cycle-free scheduler model kept in the
// bench. Directed cases cover the empty table, zero and maximum bursts, tie
// breaking and a full table. Back-pressure is exercised and a long random
// mix follows. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module sjf_dispatcher_tb;

	localparam int ENTRIES     = 16;
	localparam int IN_W        = 32;
	localparam int OUT_W       = 96;
	localparam int STATUS_W    = sjf_pkg::STATUS_W;
	localparam int WAIT_W      = sjf_pkg::WAIT_W;
	localparam int TIME_W      = sjf_pkg::TIME_W;
	localparam int MODE_W      = sjf_pkg::MODE_W;
	localparam int JOB_LO      = STATUS_W;
	localparam int BURST_LO    = JOB_LO + 8;
	localparam int WAIT_LO     = BURST_LO + 16;
	localparam int TIME_LO     = WAIT_LO + WAIT_W;
	// mode left unused by the block: accepted and dropped without a result
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	// bursts at or above this are parked: never dispatched, so runs stay short
	localparam int PARK_BURST  = 256;
	localparam int MAX_PARKED  = 3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 64;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [7:0]          job;
		logic [15:0]         burst;
		logic [WAIT_W-1:0]   waited;
		logic [TIME_W-1:0]   stamp;
	} sched_result_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// scheduler model state
	logic [7:0]        rq_id[ENTRIES];
	logic [15:0]       rq_burst[ENTRIES];
	logic [WAIT_W-1:0] rq_wait[ENTRIES];
	int                rq_fill   = 0;
	bit                cpu_busy  = 1'b0;
	logic [7:0]        run_job   = '0;
	logic [15:0]       run_left  = '0;
	logic [TIME_W-1:0] now_t     = '0;

	sched_result_t expected_results[$];
	int            mismatches    = 0;
	int            src_idle_pct  = 0;
	int            sink_idle_pct = 0;
	int            hold_ask      = 0;
	int            hold_seen     = 0;
	int            sink_hold     = 0;
	int            sink_gap      = 0;
	int            sink_cycles   = 0;

	sjf_dispatcher u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(9) == 0) ? int'($urandom_range(40, 8))
			: int'($urandom_range(3, 1));
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 15;
			default: return 50;
		endcase
	endfunction

	function automatic logic [7:0] rand_id();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [15:0] rand_burst();
		return 16'($urandom_range(65535));
	endfunction

	// advance the model by one accepted request and queue what it returns
	function automatic void predict_request(logic [MODE_W-1:0] mode, logic [7:0] id,
		logic [15:0] burst);
		sched_result_t r;
		int best;
		r = '{sjf_pkg::STAT_INSERTED, 8'd0, 16'd0, '0, '0};
		case (mode)
			sjf_pkg::MODE_INSERT: begin
				if (rq_fill >= ENTRIES) begin
					r.status = sjf_pkg::STAT_DROPPED;
				end else begin
					rq_id[rq_fill]    = id;
					rq_burst[rq_fill] = burst;
					rq_wait[rq_fill]  = '0;
					rq_fill++;
				end
			end
			sjf_pkg::MODE_ADVANCE: begin
				now_t = sat_inc(now_t);
				for (int i = 0; i < rq_fill; i++)
					rq_wait[i] = sat_inc(rq_wait[i]);
				r.status = sjf_pkg::STAT_ADVANCED;
				if (cpu_busy) begin
					if (run_left != 0)
						run_left--;
					if (run_left == 0) begin
						cpu_busy = 1'b0;
						r.status = sjf_pkg::STAT_FINISHED;
						r.job    = run_job;
					end
				end
			end
			sjf_pkg::MODE_DISPATCH: begin
				if (cpu_busy || rq_fill == 0) begin
					r.status = sjf_pkg::STAT_NONE;
				end else begin
					// shortest burst, earliest entry on a tie
					best = 0;
					for (int i = 1; i < rq_fill; i++)
						if (rq_burst[i] < rq_burst[best])
							best = i;
					r.status = sjf_pkg::STAT_DISPATCHED;
					r.job    = rq_id[best];
					r.burst  = rq_burst[best];
					r.waited = rq_wait[best];
					for (int i = best; i < rq_fill - 1; i++) begin
						rq_id[i]    = rq_id[i + 1];
						rq_burst[i] = rq_burst[i + 1];
						rq_wait[i]  = rq_wait[i + 1];
					end
					rq_fill--;
					cpu_busy = 1'b1;
					run_job  = r.job;
					run_left = r.burst;
				end
			end
			default: return;
		endcase
		r.stamp = now_t;
		expected_results.push_back(r);
	endfunction

	function automatic int parked_count();
		int n;
		n = 0;
		for (int i = 0; i < rq_fill; i++)
			if (rq_burst[i] >= PARK_BURST)
				n++;
		return n;
	endfunction

	// a dispatch is safe unless it would start a parked burst
	function automatic bit dispatch_ok();
		if (cpu_busy || rq_fill == 0)
			return 1'b1;
		for (int i = 0; i < rq_fill; i++)
			if (rq_burst[i] < PARK_BURST)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [15:0] pick_burst(bit allow_parked);
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 16'($urandom_range(7));
		if (r < 88)
			return 16'($urandom_range(63, 8));
		if (r < 97 || !allow_parked)
			return 16'($urandom_range(PARK_BURST - 1, 64));
		return 16'($urandom_range(65535, PARK_BURST));
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	task automatic check_result(logic [OUT_W-1:0] d);
		sched_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result with none pending, status %0d",
				d[0 +: STATUS_W]));
			return;
		end
		want = expected_results.pop_front();
		if (d[0 +: STATUS_W] !== want.status)
			report_mismatch($sformatf("status %0d, expected %0d", d[0 +: STATUS_W],
				want.status));
		if (d[JOB_LO +: 8] !== want.job)
			report_mismatch($sformatf("out_job 0x%0h, expected 0x%0h", d[JOB_LO +: 8],
				want.job));
		if (d[BURST_LO +: 16] !== want.burst)
			report_mismatch($sformatf("out_burst 0x%0h, expected 0x%0h",
				d[BURST_LO +: 16], want.burst));
		if (d[WAIT_LO +: WAIT_W] !== want.waited)
			report_mismatch($sformatf("out_wait %0d, expected %0d", d[WAIT_LO +: WAIT_W],
				want.waited));
		if (d[TIME_LO +: TIME_W] !== want.stamp)
			report_mismatch($sformatf("out_time %0d, expected %0d", d[TIME_LO +: TIME_W],
				want.stamp));
	endtask

	// result side: check on handshake, then pick next ready (hold, gap or open)
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				sink_hold = HOLD_CYCLES;
			end
			if (sink_hold != 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(99) < sink_idle_pct) begin
				sink_gap = gap_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			sink_cycles++;
			if (sink_cycles % 256 == 0)
				sink_idle_pct = pick_idle_pct();
		end
	end

	// offer one request, wait for the handshake, then update the model
	task automatic send_request(logic [MODE_W-1:0] mode, logic [7:0] id,
		logic [15:0] burst);
		int gap;
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			gap = gap_len();
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, burst, id, mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_request(mode, id, burst);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// empty table, idle CPU, and the unused mode
	task automatic test_empty_idle();
		send_request(sjf_pkg::MODE_DISPATCH, 8'h00, 16'h0000);
		send_request(sjf_pkg::MODE_ADVANCE, 8'hFF, 16'hFFFF);
		send_request(MODE_UNUSED, 8'hA5, 16'h5A5A);
	endtask

	// widest burst stays parked; a zero burst runs and ends on the next advance
	task automatic test_extremes();
		send_request(sjf_pkg::MODE_INSERT, 8'hFF, 16'hFFFF);
		send_request(sjf_pkg::MODE_INSERT, 8'h00, 16'h0000);
		send_request(sjf_pkg::MODE_DISPATCH, 8'h00, 16'h0000);
		send_request(sjf_pkg::MODE_DISPATCH, 8'h5A, 16'hA5A5);
		send_request(sjf_pkg::MODE_ADVANCE, 8'h00, 16'h0000);
	endtask

	// equal bursts: the earlier insert goes first, the later one carries its wait
	task automatic test_tie_break();
		send_request(sjf_pkg::MODE_INSERT, 8'h01, 16'd1);
		send_request(sjf_pkg::MODE_INSERT, 8'h02, 16'd1);
		send_request(sjf_pkg::MODE_DISPATCH, 8'h00, 16'h0000);
		send_request(sjf_pkg::MODE_ADVANCE, 8'h00, 16'h0000);
		send_request(sjf_pkg::MODE_DISPATCH, 8'h00, 16'h0000);
	endtask

	// fill every entry, then one insert too many is dropped
	task automatic test_table_full();
		while (rq_fill < ENTRIES)
			send_request(sjf_pkg::MODE_INSERT, rand_id(), 16'($urandom_range(7)));
		send_request(sjf_pkg::MODE_INSERT, 8'hC3, 16'h3C3C);
	endtask

	// result side stalls for a long stretch while requests keep coming
	task automatic test_backpressure();
		src_idle_pct = 0;
		hold_ask <= hold_ask + 1;
		send_request(sjf_pkg::MODE_DISPATCH, 8'h00, 16'h0000);
		repeat (6)
			send_request(sjf_pkg::MODE_ADVANCE, rand_id(), rand_burst());
		send_request(sjf_pkg::MODE_INSERT, rand_id(), 16'($urandom_range(7)));
		wait_drained();
	endtask

	// random mix, mostly well-formed insert / dispatch / advance traffic
	task automatic test_random(int count);
		for (int k = 0; k < count; k++) begin
			int r;
			if (k % 100 == 0)
				src_idle_pct = pick_idle_pct();
			if (k % 300 == 150)
				wait_drained();
			r = $urandom_range(99);
			if (r < 3)
				send_request(MODE_UNUSED, rand_id(), rand_burst());
			else if (r < (rq_fill < 12 ? 38 : 18))
				send_request(sjf_pkg::MODE_INSERT, rand_id(),
					pick_burst(parked_count() < MAX_PARKED));
			else if (r < 62 && dispatch_ok())
				send_request(sjf_pkg::MODE_DISPATCH, rand_id(), rand_burst());
			else
				send_request(sjf_pkg::MODE_ADVANCE, rand_id(), rand_burst());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_idle();
		test_extremes();
		test_tie_break();
		test_table_full();
		test_backpressure();
		test_random(900);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("sjf_dispatcher_tb: PASS");
		else
			$display("sjf_dispatcher_tb: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("sjf_dispatcher_tb: FAIL");
		$finish;
	end

endmodule
